### design/shootdown_pending_request_table_assert.svh
// Assertion macros for the shootdown pending-request table.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef SHOOTDOWN_PENDING_REQUEST_TABLE_ASSERT_SVH
`define SHOOTDOWN_PENDING_REQUEST_TABLE_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define SPT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define SPT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/spt_pkg.sv
// Shared types, sizes and helpers of the shootdown pending-request table.
// No dependencies; imported by spt_exec and the top level.
package spt_pkg;

    localparam int NUM_CORES      = 8;
    localparam int SLOTS_PER_CORE = 8;
    localparam int ENTRY_COUNT    = NUM_CORES * SLOTS_PER_CORE;
    localparam int ENTRY_AW       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CORE_AW        = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int SLOT_AW        = (SLOTS_PER_CORE > 1) ? $clog2(SLOTS_PER_CORE) : 1;

    localparam int ID_CORE_LSB = 24;
    localparam int ID_SLOT_LSB = 16;
    localparam logic [15:0] GEN_FIRST = 16'd1;

    typedef enum logic [2:0] {
        K_ALLOC = 3'd0,
        K_ACK   = 3'd1,
        K_QUERY = 3'd2,
        K_FREE  = 3'd3,
        K_STATS = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_SLOT = 2'd1,
        ST_STALE   = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  core;
        logic [2:0]  slot;
        logic [63:0] asid;
        logic [7:0]  tgt_mask;
        logic [31:0] ack_request_id;
        logic [2:0]  ack_src;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  granted_slot;
        logic [31:0] granted_request_id;
        logic        complete;
        logic [31:0] stat_issued;
        logic [31:0] stat_targets;
        logic [31:0] stat_alloc_failures;
        logic [31:0] stat_acks;
        logic [31:0] stat_stale_acks;
    } t_out_item;

    // One slot entry; next_gen rides along with the entry it belongs to.
    typedef struct packed {
        logic [15:0] gen;
        logic [15:0] next_gen;
        logic [63:0] aspace;
        logic [7:0]  targets;
        logic [7:0]  acks;
    } t_entry;

    // Per-core counter row.
    typedef struct packed {
        logic [31:0] issued;
        logic [31:0] targets;
        logic [31:0] fails;
        logic [31:0] acks;
        logic [31:0] stale;
    } t_stat_row;

    // Decoded operation, registered at accept.
    typedef struct packed {
        logic [2:0]          kind;
        logic                range_err;
        logic                found;
        logic [SLOT_AW-1:0]  slot;
        logic [7:0]          id_core;
        logic [7:0]          id_slot;
        logic [15:0]         id_gen;
        logic [ENTRY_AW-1:0] idx;
        logic [CORE_AW-1:0]  row;
        logic [63:0]         aspace;
        logic [7:0]          tgt_mask;
        logic [2:0]          acker;
    } t_op;

    // Write-back controls from the execute stage.
    typedef struct packed {
        logic      ent_we;
        t_entry    ent_wdata;
        logic      stat_we;
        t_stat_row stat_wdata;
        logic      set_busy;
        logic      clr_busy;
    } t_wb;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage

### design/spt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/spt_exec.sv
// Execute stage: turns a decoded operation and the read entry and counter row
// into the result item and the write-back. Uses spt_pkg.
module spt_exec
    import spt_pkg::*;
(
    input  t_op       i_op,
    input  t_entry    i_entry,
    input  logic      i_entry_written,
    input  logic      i_busy,
    input  t_stat_row i_stats,
    output t_wb       o_wb,
    output t_out_item o_result
);

    logic [15:0] gen;
    logic [7:0]  ack_bit;

    always_comb begin
        gen     = i_entry_written ? i_entry.next_gen : GEN_FIRST;
        ack_bit = 8'd1 << i_op.acker;

        o_wb            = '0;
        o_wb.ent_wdata  = i_entry;
        o_wb.stat_wdata = i_stats;
        o_result        = '0;
        o_result.status = ST_OK;

        unique case (i_op.kind)
            K_ALLOC: begin
                if (i_op.range_err) begin
                    o_result.status = ST_RANGE;
                end else if (i_op.found) begin
                    o_wb.ent_we             = 1'b1;
                    o_wb.ent_wdata.gen      = gen;
                    o_wb.ent_wdata.next_gen = gen + 16'd1;
                    o_wb.ent_wdata.aspace   = i_op.aspace;
                    o_wb.ent_wdata.targets  = i_op.tgt_mask;
                    o_wb.ent_wdata.acks     = 8'd0;
                    o_wb.set_busy           = 1'b1;
                    o_wb.stat_we            = 1'b1;
                    o_wb.stat_wdata.issued  = i_stats.issued + 32'd1;
                    o_wb.stat_wdata.targets = i_stats.targets
                                            + {28'd0, popcount8(i_op.tgt_mask)};
                    o_result.granted_slot   = 3'(i_op.slot);
                    o_result.granted_request_id = {8'(i_op.row), 8'(i_op.slot), gen};
                end else begin
                    o_wb.stat_we          = 1'b1;
                    o_wb.stat_wdata.fails = i_stats.fails + 32'd1;
                    o_result.status       = ST_NO_SLOT;
                end
            end
            K_ACK: begin
                if (i_op.range_err) begin
                    o_result.status = ST_RANGE;
                end else if (i_busy && (i_entry.gen == i_op.id_gen)) begin
                    // Count only the first ack from a given core.
                    if ((i_entry.acks & ack_bit) == 8'd0) begin
                        o_wb.ent_we          = 1'b1;
                        o_wb.ent_wdata.acks  = i_entry.acks | ack_bit;
                        o_wb.stat_we         = 1'b1;
                        o_wb.stat_wdata.acks = i_stats.acks + 32'd1;
                    end
                end else begin
                    o_wb.stat_we           = 1'b1;
                    o_wb.stat_wdata.stale  = i_stats.stale + 32'd1;
                    o_result.status        = ST_STALE;
                end
            end
            K_QUERY: begin
                if (i_op.range_err) begin
                    o_result.status = ST_RANGE;
                end else begin
                    o_result.complete =
                        ((i_entry.acks & i_entry.targets) == i_entry.targets);
                end
            end
            K_FREE: begin
                if (i_op.range_err) begin
                    o_result.status = ST_RANGE;
                end else begin
                    o_wb.clr_busy = 1'b1;
                end
            end
            K_STATS: begin
                if (i_op.range_err) begin
                    o_result.status = ST_RANGE;
                end else begin
                    o_result.stat_issued         = i_stats.issued;
                    o_result.stat_targets        = i_stats.targets;
                    o_result.stat_alloc_failures = i_stats.fails;
                    o_result.stat_acks           = i_stats.acks;
                    o_result.stat_stale_acks     = i_stats.stale;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### design/shootdown_pending_request_table.sv
// Top level of the shootdown pending-request table: decode, slot and counter
// memories, execute stage and output register. Uses spt_pkg, spt_ram, spt_exec.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one operation per
//   item: alloc, ack, query complete, free slot or statistics read. The output
//   channel (o_out_valid / i_out_ready / o_out_item) returns exactly one result
//   item for each input item, in order.
//   Order: the operation is registered at accept, executed in EXEC, and the
//   result is registered in the output register. One item is in flight at a
//   time; a new item is taken only back in IDLE. The slot entry memory and the
//   per-core counter memory each take one read (issued at accept) and at most
//   one write-back (in the execute cycle) per item, as a read-modify-write.
//   Stall: a result held in the output register does not block the next
//   accept; the execute cycle waits only while that register is still full.
//   Reset: all slots free, every slot generation at 1, every counter zero.
//   Per-entry and per-row valid flip-flops provide these values at once, so
//   there is no clearing pass and the block takes items right after reset.
module shootdown_pending_request_table
    import spt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [ENTRY_COUNT-1:0] r_busy;
    logic [ENTRY_COUNT-1:0] r_written;   // entry allocated at least once
    logic [NUM_CORES-1:0]   r_stat_valid; // counter row written at least once

    logic      r_out_valid;
    t_out_item r_out_item;

    logic in_accept;
    logic fire;

    t_entry    ent_rdata;
    t_stat_row stat_rdata;
    t_stat_row stat_view;
    t_wb       wb;
    t_out_item result;

    // ---------------------------------------------------------------
    // Decode at accept: range checks, lowest free slot, entry index
    // ---------------------------------------------------------------
    logic [SLOTS_PER_CORE-1:0] core_busy;
    logic                      free_found;
    logic [SLOT_AW-1:0]        free_slot;
    logic [31:0]               idx_wide;
    logic                      core_ok;
    logic                      slot_ok;
    logic [7:0]                dc;
    logic [7:0]                ds;

    assign in_accept = i_in_valid && o_in_ready;

    always_comb begin
        core_ok = 32'(i_in_item.core) < 32'(NUM_CORES);
        slot_ok = 32'(i_in_item.slot) < 32'(SLOTS_PER_CORE);
        dc      = i_in_item.ack_request_id[ID_CORE_LSB +: 8];
        ds      = i_in_item.ack_request_id[ID_SLOT_LSB +: 8];

        core_busy = '1;
        for (int s = 0; s < SLOTS_PER_CORE; s++) begin
            if (core_ok) begin
                core_busy[s] = r_busy[ENTRY_AW'(32'(i_in_item.core) * SLOTS_PER_CORE + s)];
            end
        end

        // Scan from the top so the lowest free slot wins.
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = SLOTS_PER_CORE - 1; s >= 0; s--) begin
            if (!core_busy[s]) begin
                free_found = 1'b1;
                free_slot  = SLOT_AW'(s);
            end
        end

        n_op             = '0;
        n_op.kind        = i_in_item.kind;
        n_op.aspace      = i_in_item.asid;
        n_op.tgt_mask    = i_in_item.tgt_mask;
        n_op.acker       = i_in_item.ack_src;
        n_op.id_core     = dc;
        n_op.id_slot     = ds;
        n_op.id_gen      = i_in_item.ack_request_id[15:0];
        n_op.found       = free_found;
        n_op.row         = CORE_AW'(i_in_item.core);
        n_op.slot        = SLOT_AW'(i_in_item.slot);
        idx_wide = 32'(i_in_item.core) * SLOTS_PER_CORE + 32'(i_in_item.slot);

        unique case (i_in_item.kind)
            K_ALLOC: begin
                n_op.range_err = !core_ok;
                n_op.slot      = free_slot;
                idx_wide = 32'(i_in_item.core) * SLOTS_PER_CORE + 32'(free_slot);
            end
            K_ACK: begin
                n_op.range_err = (32'(dc) >= 32'(NUM_CORES))
                              || (32'(ds) >= 32'(SLOTS_PER_CORE));
                n_op.row       = CORE_AW'(dc);
                idx_wide       = 32'(dc) * SLOTS_PER_CORE + 32'(ds);
            end
            K_QUERY, K_FREE: begin
                n_op.range_err = !(core_ok && slot_ok);
            end
            K_STATS: begin
                n_op.range_err = !core_ok;
            end
            default: begin
            end
        endcase
        n_op.idx = idx_wide[ENTRY_AW-1:0];
    end

    // ---------------------------------------------------------------
    // Control: accept in IDLE, execute and write back in EXEC
    // ---------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        fire       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // Take nothing while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // Hold here while the previous result still waits.
                if (!r_out_valid || i_out_ready) begin
                    fire    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op <= n_op;
        end
    end

    // ---------------------------------------------------------------
    // Memories: slot entries and per-core counter rows
    // ---------------------------------------------------------------
    spt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRY_COUNT)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (fire && wb.ent_we),
        .i_waddr (r_op.idx),
        .i_wdata (wb.ent_wdata),
        .i_re    (in_accept),
        .i_raddr (n_op.idx),
        .o_rdata (ent_rdata)
    );

    spt_ram #(
        .WIDTH ($bits(t_stat_row)),
        .DEPTH (NUM_CORES)
    ) u_stat_ram (
        .i_clk   (i_clk),
        .i_we    (fire && wb.stat_we),
        .i_waddr (r_op.row),
        .i_wdata (wb.stat_wdata),
        .i_re    (in_accept),
        .i_raddr (n_op.row),
        .o_rdata (stat_rdata)
    );

    // A counter row never written reads as zero.
    assign stat_view = r_stat_valid[r_op.row] ? stat_rdata : '0;

    spt_exec u_exec (
        .i_op            (r_op),
        .i_entry         (ent_rdata),
        .i_entry_written (r_written[r_op.idx]),
        .i_busy          (r_busy[r_op.idx]),
        .i_stats         (stat_view),
        .o_wb            (wb),
        .o_result        (result)
    );

    // Valid and busy flags: cleared at reset, updated at write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= '0;
            r_written    <= '0;
            r_stat_valid <= '0;
        end else if (fire) begin
            if (wb.set_busy) begin
                r_busy[r_op.idx]    <= 1'b1;
                r_written[r_op.idx] <= 1'b1;
            end
            if (wb.clr_busy) begin
                r_busy[r_op.idx] <= 1'b0;
            end
            if (wb.stat_we) begin
                r_stat_valid[r_op.row] <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `include "shootdown_pending_request_table_assert.svh"

    `SPT_ASSERT_NXT(a_accept_to_exec, in_accept, r_state == S_EXEC, "accept did not enter execute")
    `SPT_ASSERT_IMP(a_out_from_exec, $rose(r_out_valid), $past(r_state == S_EXEC), "result without execute")
    `SPT_ASSERT_NXT(a_alloc_sets_busy, fire && wb.set_busy, r_busy[$past(r_op.idx)], "alloc left slot free")
    `SPT_ASSERT_IMP(a_no_write_range, fire && r_op.range_err, !wb.ent_we && !wb.stat_we, "write on range error")

endmodule
